// ----- hw/rtl/bfa_pkg.sv -----
`default_nettype none
package bfa_pkg;

  localparam int FRAME_W = 20;
  localparam int CNT_W   = 11;
  localparam int REG_W   = 32;
  localparam int CFG_AW  = 3;
  localparam int REG_SEL = 2;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 11'd1024;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_ALLOC_AT = 2'd1;
  localparam logic [1:0] OP_FREE     = 2'd2;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_SAME    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] frame_number;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] granted_frame;
    logic [CNT_W-1:0]   used_frames;
  } out_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_base;
    logic [CNT_W-1:0]   frame_count;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bfa_map_ram.sv -----
`default_nettype none
module bfa_map_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bfa_regs.sv -----
`default_nettype none
module bfa_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bfa_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bfa_pkg::REG_W-1:0]    pwdata,
  output logic      [bfa_pkg::REG_W-1:0]    prdata,
  output logic                              pready,
  output bfa_pkg::cfg_t                     cfg
);

  bfa_pkg::cfg_t cfg_r;
  bfa_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic          sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = paddr[bfa_pkg::REG_SEL];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      if (sel == bfa_pkg::REG_BASE) begin
        cfg_nxt.frame_base = pwdata[bfa_pkg::FRAME_W-1:0];
      end else begin
        cfg_nxt.frame_count = pwdata[bfa_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (sel == bfa_pkg::REG_COUNT) begin
      prdata = bfa_pkg::REG_W'(cfg_r.frame_count);
    end else begin
      prdata = bfa_pkg::REG_W'(cfg_r.frame_base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_base  <= '0;
      cfg_r.frame_count <= bfa_pkg::FRAME_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bfa_ctrl.sv -----
`default_nettype none
module bfa_ctrl #(
  parameter int MAX_FRAMES = 1024,
  parameter int WORD_BITS  = 32,
  parameter int MAP_WORDS  = 32,
  parameter int WADDR_W    = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bfa_pkg::cfg_t        cfg,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bfa_pkg::in_t         in_data,
  output logic                      out_valid,
  output bfa_pkg::out_t             out_data,
  output logic                      mem_we,
  output logic [WADDR_W-1:0]        mem_waddr,
  output logic [WORD_BITS-1:0]      mem_wdata,
  output logic                      mem_re,
  output logic [WADDR_W-1:0]        mem_raddr,
  input  wire logic [WORD_BITS-1:0] mem_rdata
);

  localparam int IDX_W  = $clog2(MAX_FRAMES + 1);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int NW     = IDX_W > bfa_pkg::CNT_W ? IDX_W : bfa_pkg::CNT_W;
  localparam int DIV_SH = IDX_W + BIT_W;
  localparam int RECIP  = (1 << DIV_SH) / WORD_BITS;
  localparam int PROD_W = IDX_W + DIV_SH;
  localparam int FW     = bfa_pkg::FRAME_W;
  localparam int CW     = bfa_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MUL,
    ST_DIVQ,
    ST_RD,
    ST_CHK,
    ST_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [WADDR_W-1:0]  word_r, word_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [IDX_W:0]      wbase_r, wbase_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic                use_rd_r, use_rd_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [IDX_W-1:0]    lowest_r, lowest_nxt;
  logic                out_valid_r, out_valid_nxt;
  bfa_pkg::out_t       out_r, out_nxt;

  logic [NW-1:0]       fc_w;
  logic [IDX_W-1:0]    win_n;
  logic [FW-1:0]       diff;
  logic                in_range;
  logic                used_full;
  logic [IDX_W-1:0]    q;
  logic [IDX_W:0]      qmul;
  logic [IDX_W:0]      rem;
  logic [IDX_W-1:0]    q_c;
  logic [IDX_W:0]      rem_c;
  logic                cur_bit;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] scan_word;
  logic [BIT_W-1:0]    scan_start;
  logic                found;
  logic [BIT_W-1:0]    pos;
  logic [IDX_W:0]      hit_idx;
  logic [IDX_W:0]      next_base;
  logic [IDX_W:0]      n_ext;
  logic [FW-1:0]       grant;

  assign fc_w      = NW'(cfg.frame_count);
  assign win_n     = (fc_w > NW'(MAX_FRAMES)) ? IDX_W'(MAX_FRAMES) : IDX_W'(fc_w);
  assign n_ext     = (IDX_W+1)'(win_n);
  assign diff      = in_data.frame_number - cfg.frame_base;
  assign in_range  = (in_data.frame_number >= cfg.frame_base) && (diff < FW'(win_n));
  assign used_full = NW'(used_r) >= NW'(win_n);
  assign grant     = cfg.frame_base + FW'(idx_r);

  assign q    = prod_r[PROD_W-1:DIV_SH];
  assign qmul = {1'b0, q} * (IDX_W+1)'(WORD_BITS);
  assign rem  = {1'b0, idx_r} - qmul;

  always_comb begin
    if (rem >= (IDX_W+1)'(WORD_BITS)) begin
      q_c   = q + 1'b1;
      rem_c = rem - (IDX_W+1)'(WORD_BITS);
    end else begin
      q_c   = q;
      rem_c = rem;
    end
  end

  assign cur_bit    = mem_rdata[bit_r];
  assign onehot     = WORD_BITS'(1) << bit_r;
  assign scan_word  = use_rd_r ? mem_rdata : data_r;
  assign scan_start = use_rd_r ? '0 : bit_r;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!scan_word[i] && (BIT_W'(i) >= scan_start)) begin
        found = 1'b1;
        pos   = BIT_W'(i);
      end
    end
  end

  assign hit_idx   = wbase_r + (IDX_W+1)'(pos);
  assign next_base = wbase_r + (IDX_W+1)'(WORD_BITS);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    wbase_nxt     = wbase_r;
    data_nxt      = data_r;
    use_rd_nxt    = use_rd_r;
    used_nxt      = used_r;
    lowest_nxt    = lowest_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = word_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = word_r;

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        if (word_r == WADDR_W'(MAP_WORDS - 1)) begin
          word_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_nxt                = in_data.operation;
          out_nxt.granted_frame = '0;
          out_nxt.used_frames   = used_r;
          if (in_data.operation == bfa_pkg::OP_ALLOC) begin
            idx_nxt = lowest_r;
          end else begin
            idx_nxt = IDX_W'(diff);
          end
          case (in_data.operation)
            bfa_pkg::OP_ALLOC: begin
              if (used_full || lowest_r >= win_n) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = bfa_pkg::STAT_NO_FREE;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            bfa_pkg::OP_ALLOC_AT: begin
              if (!in_range) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = bfa_pkg::STAT_RANGE;
              end else if (used_full) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = bfa_pkg::STAT_NO_FREE;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            bfa_pkg::OP_FREE: begin
              if (!in_range) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = bfa_pkg::STAT_RANGE;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = bfa_pkg::STAT_RANGE;
            end
          endcase
        end
      end

      ST_MUL: begin
        prod_nxt  = PROD_W'(idx_r) * PROD_W'(RECIP);
        state_nxt = ST_DIVQ;
      end

      ST_DIVQ: begin
        word_nxt  = WADDR_W'(q_c);
        bit_nxt   = BIT_W'(rem_c);
        wbase_nxt = {1'b0, idx_r} - rem_c;
        state_nxt = ST_RD;
      end

      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        out_nxt.granted_frame = '0;
        out_nxt.status        = bfa_pkg::STAT_OK;
        if (op_r == bfa_pkg::OP_FREE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (!cur_bit) begin
            out_nxt.status      = bfa_pkg::STAT_SAME;
            out_nxt.used_frames = used_r;
          end else begin
            mem_we                = 1'b1;
            mem_wdata             = mem_rdata & ~onehot;
            used_nxt              = (used_r == '0) ? '0 : used_r - 1'b1;
            out_nxt.used_frames   = used_nxt;
            out_nxt.granted_frame = grant;
            if (idx_r < lowest_r) begin
              lowest_nxt = idx_r;
            end
          end
        end else if (cur_bit) begin
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
          out_nxt.used_frames = used_r;
          out_nxt.status      = (op_r == bfa_pkg::OP_ALLOC) ? bfa_pkg::STAT_NO_FREE
                                                             : bfa_pkg::STAT_SAME;
        end else begin
          mem_we                = 1'b1;
          mem_wdata             = mem_rdata | onehot;
          used_nxt              = used_r + 1'b1;
          out_nxt.used_frames   = used_nxt;
          out_nxt.granted_frame = grant;
          if (idx_r == lowest_r) begin
            data_nxt   = mem_rdata | onehot;
            use_rd_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (found) begin
          lowest_nxt    = (hit_idx >= n_ext) ? win_n : IDX_W'(hit_idx);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (next_base >= n_ext) begin
          lowest_nxt    = win_n;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          wbase_nxt  = next_base;
          word_nxt   = word_r + 1'b1;
          mem_re     = 1'b1;
          mem_raddr  = word_r + 1'b1;
          use_rd_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      word_r      <= '0;
      used_r      <= '0;
      lowest_r    <= '0;
      use_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      used_r      <= used_nxt;
      lowest_r    <= lowest_nxt;
      use_rd_r    <= use_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    prod_r  <= prod_nxt;
    bit_r   <= bit_nxt;
    wbase_r <= wbase_nxt;
    data_r  <= data_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_frame_allocator_top.sv -----
// Channel   Ports                                   Handshake
// input     start, busy, in_data                    word taken when start && !busy
// result    out_valid, out_data                     one-cycle strobe, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,   written on psel && penable && pwrite
//           prdata, pready                          (pready tied high)
//
// Rejected items (range, full, hint past window, bad code): result in the cycle after accept.
// Other items: states MUL, DIVQ (index split), RD (map read), CHK (update); an allocate
// that takes the lowest free frame then scans the bitmap a word at a time in SCAN, up to
// MAX_FRAMES/WORD_BITS words, through the single map read port.
// After reset, busy stays high while the map is cleared one word at a time.
// The receiver cannot stall; results are never held.
`default_nettype none
module bitmap_frame_allocator_top #(
  parameter int MAX_FRAMES = 1024,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bfa_pkg::in_t                in_data,
  output logic                             out_valid,
  output bfa_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bfa_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bfa_pkg::REG_W-1:0]   pwdata,
  output logic      [bfa_pkg::REG_W-1:0]   prdata,
  output logic                             pready
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;

  bfa_pkg::cfg_t        cfg;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WADDR_W-1:0]   mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bfa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bfa_map_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfa_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS),
    .MAP_WORDS  (MAP_WORDS),
    .WADDR_W    (WADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/bfa_checker.sv -----
`default_nettype none
module bfa_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire bfa_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire bfa_pkg::out_t out_data
);

  a_err_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bfa_pkg::STAT_OK) |-> out_data.granted_frame == '0)
    else $error("granted frame nonzero on error result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.operation != bfa_pkg::OP_ALLOC)
      && (in_data.operation != bfa_pkg::OP_ALLOC_AT)
      && (in_data.operation != bfa_pkg::OP_FREE)
    |=> out_valid && (out_data.status == bfa_pkg::STAT_RANGE))
    else $error("unused operation code not rejected");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |=> busy && !out_valid)
    else $error("busy dropped right after rising");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/sv/tb_bitmap_frame_allocator_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_bitmap_frame_allocator_top;
  import bfa_pkg::*;

  localparam int MAXF        = 1024;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class alloc_scoreboard;
    bit                 occ[MAXF];
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   hint;
    logic [FRAME_W-1:0] base;
    logic [CNT_W-1:0]   fcount;
    out_t               expected_grants[$];
    int                 errors;
    int                 checked;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      used    = '0;
      hint    = '0;
      base    = '0;
      fcount  = FRAME_COUNT_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function int unsigned window();
      return (fcount > MAXF) ? MAXF : fcount;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function void set_reg(logic sel, logic [REG_W-1:0] val);
      if (sel == REG_BASE) begin
        base = val[FRAME_W-1:0];
      end else begin
        fcount = val[CNT_W-1:0];
      end
    endfunction

    function void take(int unsigned idx, int unsigned n);
      int unsigned k;
      occ[idx] = 1'b1;
      used = used + 1'b1;
      if (idx == hint) begin
        k = idx;
        while (k < n && occ[k]) k++;
        hint = CNT_W'(k);
      end
    endfunction

    function void apply_request(in_t w);
      int unsigned        n;
      int unsigned        idx;
      logic [FRAME_W-1:0] off;
      bit                 in_win;
      status_t            st;
      out_t               exp_grant;
      n      = window();
      off    = w.frame_number - base;
      in_win = (w.frame_number >= base) && (off < n);
      st     = STAT_OK;
      idx    = off;
      case (w.operation)
        OP_ALLOC: begin
          idx = hint;
          if (used >= n || idx >= n || occ[idx]) st = STAT_NO_FREE;
          else take(idx, n);
        end
        OP_ALLOC_AT: begin
          if (!in_win) st = STAT_RANGE;
          else if (used >= n) st = STAT_NO_FREE;
          else if (occ[idx]) st = STAT_SAME;
          else take(idx, n);
        end
        OP_FREE: begin
          if (!in_win) st = STAT_RANGE;
          else if (!occ[idx]) st = STAT_SAME;
          else begin
            occ[idx] = 1'b0;
            if (used > 0) used = used - 1'b1;
            if (idx < hint) hint = CNT_W'(idx);
          end
        end
        default: st = STAT_RANGE;
      endcase
      exp_grant.status        = st;
      exp_grant.granted_frame = (st == STAT_OK) ? base + FRAME_W'(idx) : '0;
      exp_grant.used_frames   = used;
      expected_grants.push_back(exp_grant);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task match_grant(out_t got);
      out_t want;
      if (expected_grants.size() == 0) begin
        report("result word with nothing outstanding");
      end else begin
        want = expected_grants.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("status got %0d want %s", got.status, want.status.name()));
        if (got.granted_frame !== want.granted_frame)
          report($sformatf("granted_frame got %h want %h",
                           got.granted_frame, want.granted_frame));
        if (got.used_frames !== want.used_frames)
          report($sformatf("used_frames got %0d want %0d",
                           got.used_frames, want.used_frames));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_t                 in_data;
  logic                out_valid;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [REG_W-1:0]    pwdata;
  logic [REG_W-1:0]    prdata;
  logic                pready;

  alloc_scoreboard sb;
  bit allow_gaps;
  int n_cmds;
  int n_directed;
  int n_writes;
  int idle_cycles;

  bitmap_frame_allocator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.match_grant(out_data);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(logic [1:0] op, logic [FRAME_W-1:0] fn);
    in_t w;
    int  r;
    int  g;
    w.operation    = op;
    w.frame_number = fn;
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.apply_request(w);
    n_cmds++;
    if (allow_gaps) begin
      r = $urandom_range(0, 99);
      g = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (g > 0) begin
        start <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic cfg_write(logic sel, logic [REG_W-1:0] val);
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(sel, val);
    n_writes++;
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [FRAME_W-1:0] window_frame();
    int unsigned n;
    n = sb.window();
    if (n == 0) return FRAME_W'($urandom);
    return sb.base + FRAME_W'($urandom_range(0, n - 1));
  endfunction

  initial begin
    logic [FRAME_W-1:0] b;
    logic [CNT_W-1:0]   c;
    logic [CNT_W-1:0]   h;
    int                 cnt;
    int                 r;
    int                 len;
    sb          = new();
    allow_gaps  = 1'b1;
    n_cmds      = 0;
    n_writes    = 0;
    idle_cycles = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // window straddling the top of the frame space, small enough to fill
    cfg_write(REG_BASE, 32'h000F_FFF8);
    cfg_write(REG_COUNT, 32'd10);
    cfg_release();
    issue(OP_ALLOC, 20'h00000);
    issue(OP_ALLOC_AT, 20'hFFFFA);
    issue(OP_ALLOC_AT, 20'hFFFFA);
    issue(OP_ALLOC, 20'hFFFFF);
    issue(OP_FREE, 20'hFFFFF);
    issue(OP_FREE, 20'hFFFF9);
    issue(OP_ALLOC_AT, 20'h00000);
    issue(OP_ALLOC_AT, 20'hFFFFF);
    issue(OP_UNUSED, 20'hFFFFF);
    repeat (9) issue(OP_ALLOC, FRAME_W'($urandom));
    issue(OP_ALLOC_AT, 20'hFFFFB);
    issue(OP_FREE, 20'hFFFF7);
    drain();

    // empty window
    cfg_write(REG_COUNT, 32'd0);
    cfg_release();
    issue(OP_ALLOC, 20'h00000);
    issue(OP_FREE, 20'hFFFF8);
    drain();

    // count above the map depth clamps to the full map
    cfg_write(REG_BASE, 32'hFFF0_0000);
    cfg_write(REG_COUNT, 32'h0000_07FF);
    cfg_release();
    issue(OP_ALLOC_AT, 20'd1023);
    issue(OP_FREE, 20'd1024);
    issue(OP_FREE, 20'd1023);
    issue(OP_ALLOC_AT, 20'hFFFFF);
    n_directed = n_cmds;

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: b = '0;
        1: b = 20'hFFFFF - FRAME_W'($urandom_range(0, 40));
        2: b = FRAME_W'($urandom);
        default: b = FRAME_W'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 5))
        0: c = 11'd1;
        1: c = 11'd1024;
        2: c = 11'h7FF;
        3: c = CNT_W'($urandom_range(2, 16));
        4: c = CNT_W'($urandom_range(17, 100));
        default: c = CNT_W'($urandom_range(0, 2047));
      endcase
      if (ph == 0) begin
        b = '0;
        c = 11'd1024;
      end else if (ph == 1) begin
        b = 20'hFFFFF;
        c = 11'd1;
      end
      cfg_write(REG_BASE, {12'($urandom), b});
      cfg_write(REG_COUNT, {21'($urandom), c});
      cfg_release();
      allow_gaps = (ph % 3 != 2);
      cnt = 0;
      while (cnt < 48) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          issue(OP_ALLOC, FRAME_W'($urandom));
          cnt++;
        end else if (r < 50) begin
          issue(OP_ALLOC_AT, window_frame());
          cnt++;
        end else if (r < 75) begin
          issue(OP_FREE, window_frame());
          cnt++;
        end else if (r < 87) begin
          // occupy a run above the lowest free frame, then take it to force a scan
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(2, 40);
          if (len > 47 - cnt) len = 47 - cnt;
          h = sb.hint;
          for (int j = 1; j <= len; j++)
            issue(OP_ALLOC_AT, sb.base + FRAME_W'(h) + FRAME_W'(j));
          issue(OP_ALLOC, FRAME_W'($urandom));
          cnt += len + 1;
        end else begin
          case ($urandom_range(0, 2))
            0: issue(OP_UNUSED, FRAME_W'($urandom));
            1: issue(OP_ALLOC_AT, FRAME_W'($urandom));
            default: issue(OP_FREE, FRAME_W'($urandom));
          endcase
          cnt++;
        end
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("run: %0d commands (%0d directed) over 15 register settings, %0d writes",
             n_cmds, n_directed, n_writes);
    $display("run: %0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
